/* rtl/ralu_pkg.sv */
package ralu_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned INDEX_W = 10;
	localparam int unsigned WORD_W  = 3;

	// word indices in the window
	localparam logic [WORD_W-1:0] W_CONTROL   = 3'd0;
	localparam logic [WORD_W-1:0] W_OPERATION = 3'd1;
	localparam logic [WORD_W-1:0] W_OPERAND_A = 3'd2;
	localparam logic [WORD_W-1:0] W_OPERAND_B = 3'd3;
	localparam logic [WORD_W-1:0] W_RESULT    = 3'd4;
	localparam logic [WORD_W-1:0] W_STATUS    = 3'd5;
	localparam logic [INDEX_W-1:0] NUM_WORDS  = 10'd6;

	localparam logic CMD_WRITE = 1'b1;

	localparam int unsigned CTL_START_BIT = 0;
	localparam int unsigned CTL_RESET_BIT = 1;

	localparam logic [DATA_W-1:0] ST_READY   = 32'h0000_0001;
	localparam logic [DATA_W-1:0] ST_DONE    = 32'h0000_0002;
	localparam logic [DATA_W-1:0] ST_ERROR   = 32'h0000_0004;
	localparam logic [DATA_W-1:0] ST_DIVZERO = 32'h0000_0008;

	localparam logic [DATA_W-1:0] OP_ADD = 32'd0;
	localparam logic [DATA_W-1:0] OP_SUB = 32'd1;
	localparam logic [DATA_W-1:0] OP_MUL = 32'd2;
	localparam logic [DATA_W-1:0] OP_DIV = 32'd3;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		K_READ,
		K_WRITE,
		K_RESET,
		K_START,
		K_IGNORE
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [WORD_W-1:0]  word;
		logic [DATA_W-1:0]  data;
	} cmd_t;

endpackage

/* rtl/ralu_if.sv */
interface ralu_req_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic [ralu_pkg::INDEX_W-1:0]        reg_index;
	logic [ralu_pkg::DATA_W-1:0]         write_data;

	modport source (output valid, output cmd, output reg_index, output write_data, input ready);
	modport sink (input valid, input cmd, input reg_index, input write_data, output ready);
endinterface

interface ralu_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [ralu_pkg::DATA_W-1:0]         read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

/* rtl/ralu_front.sv */
module ralu_front (
	ralu_req_if.sink         req,
	output logic             push_valid,
	input  logic             push_ready,
	output ralu_pkg::cmd_t   push_cmd
);

	logic mapped;

	assign mapped     = (req.reg_index < ralu_pkg::NUM_WORDS);
	assign push_valid = req.valid;
	assign req.ready  = push_ready;

	always_comb begin
		push_cmd.word = req.reg_index[ralu_pkg::WORD_W-1:0];
		push_cmd.data = req.write_data;
		if (!mapped) begin
			push_cmd.kind = ralu_pkg::K_IGNORE;
		end else if (push_cmd.word == ralu_pkg::W_CONTROL) begin
			// control reads 0; RESET wins over START
			if (req.cmd != ralu_pkg::CMD_WRITE) begin
				push_cmd.kind = ralu_pkg::K_IGNORE;
			end else if (req.write_data[ralu_pkg::CTL_RESET_BIT]) begin
				push_cmd.kind = ralu_pkg::K_RESET;
			end else if (req.write_data[ralu_pkg::CTL_START_BIT]) begin
				push_cmd.kind = ralu_pkg::K_START;
			end else begin
				push_cmd.kind = ralu_pkg::K_IGNORE;
			end
		end else if (req.cmd == ralu_pkg::CMD_WRITE) begin
			push_cmd.kind = ralu_pkg::K_WRITE;
		end else begin
			push_cmd.kind = ralu_pkg::K_READ;
		end
	end

endmodule

/* rtl/ralu_queue.sv */
module ralu_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  ralu_pkg::cmd_t   push_cmd,
	output logic             pop_valid,
	input  logic             pop_ready,
	output ralu_pkg::cmd_t   pop_cmd
);

	localparam int unsigned PTR_W = $clog2(ralu_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(ralu_pkg::QUEUE_DEPTH + 1);

	ralu_pkg::cmd_t    entry_q [ralu_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(ralu_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ralu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ralu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/ralu_exec.sv */
module ralu_exec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  ralu_pkg::cmd_t   pop_cmd,
	ralu_rsp_if.source       rsp
);

	localparam int unsigned DW    = ralu_pkg::DATA_W;
	localparam int unsigned CNT_W = $clog2(ralu_pkg::DATA_W);

	typedef enum logic {
		S_IDLE,
		S_DIV
	} state_t;

	state_t            state_q;
	logic [DW-1:0]     op_q;
	logic [DW-1:0]     a_q;
	logic [DW-1:0]     b_q;
	logic [DW-1:0]     res_q;
	logic [DW-1:0]     stat_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [DW-1:0]     rdata_q;

	logic              take;
	logic              div_start;
	logic [DW:0]       shifted;
	logic [DW+1:0]     diff;
	logic              ge;
	logic [DW-1:0]     rem_next;
	logic [DW-1:0]     rd_word;
	logic [2*DW-1:0]   product;

	assign pop_ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign take      = pop_valid && pop_ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = rdata_q;
	assign div_start = (pop_cmd.kind == ralu_pkg::K_START) && (op_q == ralu_pkg::OP_DIV) &&
		(b_q != '0);

	// one restoring divide step per cycle
	assign shifted  = {rem_q, quo_q[DW-1]};
	assign diff     = {1'b0, shifted} - {2'b00, b_q};
	assign ge       = ~diff[DW+1];
	assign rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
	assign product  = a_q * b_q;

	always_comb begin
		case (pop_cmd.word)
			ralu_pkg::W_OPERATION: rd_word = op_q;
			ralu_pkg::W_OPERAND_A: rd_word = a_q;
			ralu_pkg::W_OPERAND_B: rd_word = b_q;
			ralu_pkg::W_RESULT:    rd_word = res_q;
			ralu_pkg::W_STATUS:    rd_word = stat_q;
			default:               rd_word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			res_q       <= '0;
			stat_q      <= ralu_pkg::ST_READY;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			rdata_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						// hold the beat of a divide until the quotient is in
						out_valid_q <= !div_start;
						rdata_q     <= (pop_cmd.kind == ralu_pkg::K_READ) ? rd_word : '0;
						case (pop_cmd.kind)
							ralu_pkg::K_WRITE: begin
								case (pop_cmd.word)
									ralu_pkg::W_OPERATION: op_q   <= pop_cmd.data;
									ralu_pkg::W_OPERAND_A: a_q    <= pop_cmd.data;
									ralu_pkg::W_OPERAND_B: b_q    <= pop_cmd.data;
									ralu_pkg::W_RESULT:    res_q  <= pop_cmd.data;
									ralu_pkg::W_STATUS:    stat_q <= pop_cmd.data;
									default: ;
								endcase
							end
							ralu_pkg::K_RESET: begin
								res_q  <= '0;
								stat_q <= ralu_pkg::ST_READY;
							end
							ralu_pkg::K_START: begin
								if (op_q > ralu_pkg::OP_DIV) begin
									stat_q <= ralu_pkg::ST_ERROR;
								end else if (op_q == ralu_pkg::OP_DIV) begin
									if (b_q == '0) begin
										stat_q <= ralu_pkg::ST_ERROR | ralu_pkg::ST_DIVZERO;
									end else begin
										rem_q       <= '0;
										quo_q       <= a_q;
										cnt_q       <= CNT_W'(DW - 1);
										state_q     <= S_DIV;
									end
								end else begin
									stat_q <= ralu_pkg::ST_READY | ralu_pkg::ST_DONE;
									if (op_q == ralu_pkg::OP_ADD) begin
										res_q <= a_q + b_q;
									end else if (op_q == ralu_pkg::OP_SUB) begin
										res_q <= a_q - b_q;
									end else begin
										res_q <= product[DW-1:0];
									end
								end
							end
							default: ;
						endcase
					end else if (out_valid_q && rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[DW-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						res_q       <= {quo_q[DW-2:0], ge};
						stat_q      <= ralu_pkg::ST_READY | ralu_pkg::ST_DONE;
						out_valid_q <= 1'b1;
						rdata_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/register_mapped_alu.sv */
// Response path: an accepted access passes the queue entry and the execute unit's
// output register; a divide START waits on the one-bit-per-cycle restoring divider.
// Throughput: one access per cycle while rsp.ready holds, except a divide START,
// which halts the pops; the two-entry queue takes up to two beats meanwhile.
// Reset: arst_n clears all words to 0 and status to READY, empties the queue.
module register_mapped_alu (
	input  logic       clk,
	input  logic       arst_n,
	ralu_req_if.sink   req,
	ralu_rsp_if.source rsp
);

	logic            push_valid;
	logic            push_ready;
	ralu_pkg::cmd_t  push_cmd;
	logic            pop_valid;
	logic            pop_ready;
	ralu_pkg::cmd_t  pop_cmd;

	ralu_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	ralu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	ralu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.rsp       (rsp)
	);

endmodule
